FILE: hw/rtl/lpmt_pkg.sv
// Shared types, constants and helpers for the longest prefix match table.
`default_nettype none
package lpmt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_BITS      = 128;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LEN_W         = 8;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int INDEX_W       = 8;
  localparam int ADDR_W        = 64;
  localparam int IPV4_BITS     = 32;
  localparam int IPV4_BASE_LEN = 96;
  localparam logic [31:0] IPV4_MAPPED_TAG = 32'h0000_ffff;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                is_ipv4;
    logic [KEY_BITS-1:0] key;
    logic [LEN_W-1:0]    len;
  } lpmt_op_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [LEN_W-1:0]    len;
    logic                is_ipv4;
  } lpmt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpmt_q_stat_t;

  typedef struct packed {
    logic busy;
    logic deciding;
  } lpmt_back_stat_t;

  // top len bits set, saturates at KEY_BITS
  function automatic logic [KEY_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({KEY_BITS{1'b1}} >> len);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lpmt_front.sv
// Input stage: accepts beats and normalizes keys into the unified 128-bit space.
`default_nettype none
module lpmt_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpmt_pkg::KIND_W-1:0]   in_kind,
  input  wire logic                          in_is_ipv4,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   in_address_high,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   in_address_low,
  input  wire logic [lpmt_pkg::LEN_W-1:0]    in_prefix_length,
  input  wire lpmt_pkg::lpmt_q_stat_t        q_stat,
  output logic                               push,
  output lpmt_pkg::lpmt_op_t                 push_op
);
  import lpmt_pkg::*;

  logic [LEN_W-1:0]    len;
  logic [KEY_BITS-1:0] raw_key;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    if (in_is_ipv4) begin
      len = LEN_W'(IPV4_BASE_LEN) +
            ((in_prefix_length > LEN_W'(IPV4_BITS)) ? LEN_W'(IPV4_BITS) : in_prefix_length);
      raw_key = {{(KEY_BITS-2*IPV4_BITS){1'b0}}, IPV4_MAPPED_TAG, in_address_low[IPV4_BITS-1:0]};
    end else begin
      len = (in_prefix_length > LEN_W'(KEY_BITS)) ? LEN_W'(KEY_BITS) : in_prefix_length;
      raw_key = {in_address_high, in_address_low};
    end
    push_op.kind    = in_kind;
    push_op.is_ipv4 = in_is_ipv4;
    push_op.len     = len;
    push_op.key     = raw_key & prefix_mask(len);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lpmt_queue.sv
// Short FIFO of normalized operations between the front and the scan engine.
`default_nettype none
module lpmt_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire lpmt_pkg::lpmt_op_t    push_op,
  input  wire logic                  pop,
  output lpmt_pkg::lpmt_op_t         head,
  output lpmt_pkg::lpmt_q_stat_t     q_stat
);
  import lpmt_pkg::*;

  lpmt_op_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign head         = slots_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lpmt_back.sv
// Scan engine: table storage, full-table scan per operation, decision and write-back.
`default_nettype none
module lpmt_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lpmt_pkg::lpmt_q_stat_t          q_stat,
  input  wire lpmt_pkg::lpmt_op_t              head,
  output logic                                 pop,
  output lpmt_pkg::lpmt_back_stat_t            back_stat,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lpmt_pkg::STATUS_W-1:0]        out_status,
  output logic [lpmt_pkg::INDEX_W-1:0]         out_match_index,
  output logic [lpmt_pkg::LEN_W-1:0]           out_match_length,
  output logic                                 out_match_is_ipv4
);
  import lpmt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  lpmt_entry_t               mem [TABLE_ENTRIES];
  lpmt_entry_t               rd_r;
  logic [TABLE_ENTRIES-1:0]  valid_r;

  state_t                    state_r;
  lpmt_op_t                  op_r;
  logic [IDX_W-1:0]          addr_r;

  logic                      s1_vld_r;
  logic                      s1_last_r;
  logic [IDX_W-1:0]          s1_idx_r;
  logic                      s1_valid_r;

  logic                      s2_vld_r;
  logic                      s2_last_r;
  logic [IDX_W-1:0]          s2_idx_r;
  logic                      s2_free_r;
  logic                      s2_exact_r;
  logic                      s2_hit_r;
  logic [LEN_W-1:0]          s2_len_r;
  logic                      s2_v4_r;

  logic                      exact_found_r;
  logic [IDX_W-1:0]          exact_idx_r;
  logic [LEN_W-1:0]          exact_len_r;
  logic                      exact_v4_r;
  logic                      free_found_r;
  logic [IDX_W-1:0]          free_idx_r;
  logic                      best_found_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [LEN_W-1:0]          best_len_r;
  logic                      best_v4_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic [LEN_W-1:0]          out_length_r;
  logic                      out_v4_r;

  logic                      out_load;
  logic                      mem_we;

  assign pop                = (state_r == S_IDLE) && !q_stat.empty;
  assign back_stat.busy     = (state_r != S_IDLE);
  assign back_stat.deciding = (state_r == S_DECIDE);
  assign out_load           = (state_r == S_DECIDE) && (!out_valid_r || !out_stall);
  assign mem_we             = out_load && (op_r.kind == KIND_INSERT) &&
                              !exact_found_r && free_found_r;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_index   = out_index_r;
  assign out_match_length  = out_length_r;
  assign out_match_is_ipv4 = out_v4_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx_r] <= '{key: op_r.key, len: op_r.len, is_ipv4: op_r.is_ipv4};
    end
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      addr_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // read stage, aligned with rd_r
      s1_vld_r   <= (state_r == S_SCAN);
      s1_last_r  <= (addr_r == LAST_IDX);
      s1_idx_r   <= addr_r;
      s1_valid_r <= valid_r[addr_r];

      // compare stage
      s2_vld_r   <= s1_vld_r;
      s2_last_r  <= s1_last_r;
      s2_idx_r   <= s1_idx_r;
      s2_free_r  <= !s1_valid_r;
      s2_exact_r <= s1_valid_r && (rd_r.len == op_r.len) && (rd_r.key == op_r.key);
      s2_hit_r   <= s1_valid_r && (rd_r.len <= op_r.len) &&
                    (!op_r.is_ipv4 || (rd_r.len >= LEN_W'(IPV4_BASE_LEN))) &&
                    ((op_r.key & prefix_mask(rd_r.len)) == rd_r.key);
      s2_len_r   <= rd_r.len;
      s2_v4_r    <= rd_r.is_ipv4;

      if (s2_vld_r) begin
        if (s2_exact_r && !exact_found_r) begin
          exact_found_r <= 1'b1;
          exact_idx_r   <= s2_idx_r;
          exact_len_r   <= s2_len_r;
          exact_v4_r    <= s2_v4_r;
        end
        if (s2_free_r && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= s2_idx_r;
        end
        if (s2_hit_r && (!best_found_r || (s2_len_r > best_len_r))) begin
          best_found_r <= 1'b1;
          best_idx_r   <= s2_idx_r;
          best_len_r   <= s2_len_r;
          best_v4_r    <= s2_v4_r;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            op_r          <= head;
            addr_r        <= '0;
            exact_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            best_found_r  <= 1'b0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (s2_vld_r && s2_last_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_NOT_FOUND;
            out_index_r  <= '0;
            out_length_r <= '0;
            out_v4_r     <= 1'b0;
            case (op_r.kind)
              KIND_INSERT: begin
                if (exact_found_r) begin
                  out_status_r <= ST_PRESENT;
                  out_index_r  <= INDEX_W'(exact_idx_r);
                  out_length_r <= exact_len_r;
                  out_v4_r     <= exact_v4_r;
                end else if (free_found_r) begin
                  out_status_r        <= ST_OK;
                  out_index_r         <= INDEX_W'(free_idx_r);
                  out_length_r        <= op_r.len;
                  out_v4_r            <= op_r.is_ipv4;
                  valid_r[free_idx_r] <= 1'b1;
                end else begin
                  out_status_r <= ST_FULL;
                end
              end
              KIND_DELETE: begin
                if (exact_found_r) begin
                  out_status_r         <= ST_OK;
                  out_index_r          <= INDEX_W'(exact_idx_r);
                  out_length_r         <= exact_len_r;
                  out_v4_r             <= exact_v4_r;
                  valid_r[exact_idx_r] <= 1'b0;
                end
              end
              KIND_SEARCH: begin
                if (best_found_r) begin
                  out_status_r <= ST_OK;
                  out_index_r  <= INDEX_W'(best_idx_r);
                  out_length_r <= best_len_r;
                  out_v4_r     <= best_v4_r;
                end
              end
              default: begin
                out_status_r <= ST_NOT_FOUND;
              end
            endcase
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/longest_prefix_match_table_core.sv
// Top level of the longest prefix match table: front, queue and scan engine.
//
// Every operation (insert, delete or search) walks the whole table once through the
// memory's read port, one entry per cycle. A beat's result register loads after the scan,
// the read and compare stages and the decision step, and the next beat leaves the queue
// only once the engine is back in idle, so a new beat is not taken from the queue until
// the last one's result is loaded. A stalled result holds the engine in its decision step.
// A two-deep queue behind the input lets new beats be taken while a scan runs, and the
// result register lets the next scan start while a result waits.
// Entry valid bits are flip-flops cleared by reset, so the table is usable right away.
`default_nettype none
module longest_prefix_match_table_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpmt_pkg::KIND_W-1:0]   in_kind,
  input  wire logic                          in_is_ipv4,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   in_address_high,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   in_address_low,
  input  wire logic [lpmt_pkg::LEN_W-1:0]    in_prefix_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lpmt_pkg::STATUS_W-1:0]      out_status,
  output logic [lpmt_pkg::INDEX_W-1:0]       out_match_index,
  output logic [lpmt_pkg::LEN_W-1:0]         out_match_length,
  output logic                               out_match_is_ipv4
);
  import lpmt_pkg::*;

  lpmt_q_stat_t    q_stat;
  lpmt_back_stat_t back_stat;
  lpmt_op_t        push_op;
  lpmt_op_t        head;
  logic            push;
  logic            pop;

  lpmt_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_is_ipv4       (in_is_ipv4),
    .in_address_high  (in_address_high),
    .in_address_low   (in_address_low),
    .in_prefix_length (in_prefix_length),
    .q_stat           (q_stat),
    .push             (push),
    .push_op          (push_op)
  );

  lpmt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  lpmt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head              (head),
    .pop               (pop),
    .back_stat         (back_stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_index   (out_match_index),
    .out_match_length  (out_match_length),
    .out_match_is_ipv4 (out_match_is_ipv4)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_pop_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> back_stat.busy && !back_stat.deciding)
    else $error("scan did not start after pop");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL) |->
      out_match_index == '0 && out_match_length == '0 && !out_match_is_ipv4)
    else $error("nonzero fields on a miss beat");

endmodule
`default_nettype wire

FILE: test/longest_prefix_match_table_core_tb.sv
// Self-checking testbench for longest_prefix_match_table_core: directed table, then random ops.
module longest_prefix_match_table_core_tb;
  import lpmt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] ALL1 = 64'hffff_ffff_ffff_ffff;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_ipv4;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic [7:0]        plen;
  } lpm_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          index;
    logic [7:0]          length;
    logic                is_ipv4;
  } lpm_reply_t;

  typedef struct packed {
    lpm_op_t    op;
    logic       typed;
    lpm_reply_t want;
  } dir_row_t;

  localparam lpm_reply_t MISS = '{ST_NOT_FOUND, 8'd0, 8'd0, 1'b0};
  localparam lpm_reply_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic in_is_ipv4 = 1'b0;
  logic [ADDR_W-1:0] in_address_high = '0;
  logic [ADDR_W-1:0] in_address_low = '0;
  logic [LEN_W-1:0] in_prefix_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0] out_match_index;
  logic [LEN_W-1:0] out_match_length;
  logic out_match_is_ipv4;

  // shadow of the prefix table
  bit          tbl_valid [TABLE_ENTRIES];
  logic [127:0] tbl_bits [TABLE_ENTRIES];
  logic [7:0]  tbl_len [TABLE_ENTRIES];
  bit          tbl_v4 [TABLE_ENTRIES];

  lpm_reply_t replies_due[$];
  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int input_held = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  dir_row_t directed_rows [24] = '{
    '{'{KIND_SEARCH, 1'b0, ALL1, ALL1, 8'd128}, 1'b1, MISS},
    '{'{KIND_DELETE, 1'b1, ALL1, ALL1, 8'd32}, 1'b1, MISS},
    '{'{KIND_UNUSED, 1'b0, ALL1, ALL1, 8'd255}, 1'b1, MISS},
    '{'{KIND_INSERT, 1'b0, ALL1, ALL1, 8'd0}, 1'b1, '{ST_OK, 8'd0, 8'd0, 1'b0}},
    '{'{KIND_INSERT, 1'b1, ALL1, 64'hffff_ffff_0000_0000, 8'd0}, 1'b1,
      '{ST_OK, 8'd1, 8'd96, 1'b1}},
    '{'{KIND_INSERT, 1'b0, 64'd0, 64'h0000_ffff_0000_0000, 8'd96}, 1'b1,
      '{ST_PRESENT, 8'd1, 8'd96, 1'b1}},
    '{'{KIND_INSERT, 1'b1, 64'd0, 64'h0000_0000_ffff_ffff, 8'd200}, 1'b1,
      '{ST_OK, 8'd2, 8'd128, 1'b1}},
    '{'{KIND_INSERT, 1'b0, ALL1, ALL1, 8'd255}, 1'b1, '{ST_OK, 8'd3, 8'd128, 1'b0}},
    '{'{KIND_SEARCH, 1'b1, 64'd0, 64'h0000_0000_0102_0304, 8'd32}, 1'b1,
      '{ST_OK, 8'd1, 8'd96, 1'b1}},
    '{'{KIND_SEARCH, 1'b0, ALL1, ALL1, 8'd128}, 1'b1, '{ST_OK, 8'd3, 8'd128, 1'b0}},
    '{'{KIND_SEARCH, 1'b1, 64'd0, 64'h0000_0000_ffff_ffff, 8'd32}, 1'b1,
      '{ST_OK, 8'd2, 8'd128, 1'b1}},
    '{'{KIND_SEARCH, 1'b0, ALL1, ALL1, 8'd64}, 1'b1, '{ST_OK, 8'd0, 8'd0, 1'b0}},
    '{'{KIND_SEARCH, 1'b1, ALL1, ALL1, 8'd0}, 1'b1, '{ST_OK, 8'd1, 8'd96, 1'b1}},
    '{'{KIND_INSERT, 1'b0, 64'h2001_0db8_ffff_ffff, 64'h0123_4567_89ab_cdef, 8'd32},
      1'b0, UNTYPED},
    '{'{KIND_SEARCH, 1'b0, 64'h2001_0db8_0000_0001, 64'd0, 8'd128}, 1'b0, UNTYPED},
    '{'{KIND_DELETE, 1'b0, 64'd0, 64'h0000_ffff_1234_5678, 8'd96}, 1'b1,
      '{ST_OK, 8'd1, 8'd96, 1'b1}},
    '{'{KIND_SEARCH, 1'b1, 64'd0, 64'h0000_0000_0102_0304, 8'd32}, 1'b1, MISS},
    '{'{KIND_DELETE, 1'b0, ALL1, ALL1, 8'd128}, 1'b1, '{ST_OK, 8'd3, 8'd128, 1'b0}},
    '{'{KIND_INSERT, 1'b0, ALL1, 64'd0, 8'd1}, 1'b1, '{ST_OK, 8'd1, 8'd1, 1'b0}},
    '{'{KIND_DELETE, 1'b1, 64'd0, 64'h0000_0000_ffff_ffff, 8'd31}, 1'b1, MISS},
    '{'{KIND_SEARCH, 1'b0, ALL1, 64'h5555_5555_5555_5555, 8'd129}, 1'b0, UNTYPED},
    '{'{KIND_UNUSED, 1'b1, 64'd0, 64'h0000_0000_0a00_0001, 8'd32}, 1'b1, MISS},
    '{'{KIND_INSERT, 1'b1, 64'd0, 64'hdead_beef_0a00_0000, 8'd8}, 1'b0, UNTYPED},
    '{'{KIND_SEARCH, 1'b1, ALL1, 64'h1234_5678_0a01_0203, 8'd33}, 1'b0, UNTYPED}
  };

  longest_prefix_match_table_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_is_ipv4        (in_is_ipv4),
    .in_address_high   (in_address_high),
    .in_address_low    (in_address_low),
    .in_prefix_length  (in_prefix_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_index   (out_match_index),
    .out_match_length  (out_match_length),
    .out_match_is_ipv4 (out_match_is_ipv4)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [127:0] len_mask(input int unsigned n);
    return (n == 0) ? '0 : ({128{1'b1}} << (128 - n));
  endfunction

  function automatic lpm_reply_t slot_reply(input logic [STATUS_W-1:0] status, input int slot);
    lpm_reply_t r;
    r.status = status;
    r.index = slot[7:0];
    r.length = tbl_len[slot];
    r.is_ipv4 = tbl_v4[slot];
    return r;
  endfunction

  function automatic int find_prefix(input logic [127:0] key, input int unsigned klen);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_len[i] == klen && tbl_bits[i] == key) return i;
    return -1;
  endfunction

  // expected reply of one operation; updates the shadow table
  function automatic lpm_reply_t apply_table_op(input lpm_op_t op);
    logic [127:0] key;
    int unsigned n;
    int unsigned klen;
    int i;
    int slot;
    lpm_reply_t r;
    r = MISS;
    n = 32'(op.plen);
    if (op.is_ipv4) begin
      if (n > IPV4_BITS) n = IPV4_BITS;
      klen = IPV4_BASE_LEN + n;
      key = {64'd0, IPV4_MAPPED_TAG, op.lo[31:0]};
    end else begin
      if (n > KEY_BITS) n = KEY_BITS;
      klen = n;
      key = {op.hi, op.lo};
    end
    key &= len_mask(klen);
    case (op.kind)
      KIND_INSERT: begin
        slot = find_prefix(key, klen);
        if (slot >= 0) return slot_reply(ST_PRESENT, slot);
        slot = -1;
        for (i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          r = '0;
          r.status = ST_FULL;
          return r;
        end
        tbl_valid[slot] = 1'b1;
        tbl_bits[slot] = key;
        tbl_len[slot] = klen[7:0];
        tbl_v4[slot] = op.is_ipv4;
        r = slot_reply(ST_OK, slot);
      end
      KIND_DELETE: begin
        slot = find_prefix(key, klen);
        if (slot >= 0) begin
          r = slot_reply(ST_OK, slot);
          tbl_valid[slot] = 1'b0;
        end
      end
      KIND_SEARCH: begin
        slot = -1;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (!tbl_valid[i] || tbl_len[i] > klen) continue;
          if (op.is_ipv4 && tbl_len[i] < IPV4_BASE_LEN) continue;
          if ((key & len_mask(tbl_len[i])) != tbl_bits[i]) continue;
          if (slot < 0 || tbl_len[i] > tbl_len[slot]) slot = i;
        end
        if (slot >= 0) r = slot_reply(ST_OK, slot);
      end
      default: r = MISS;
    endcase
    return r;
  endfunction

  function automatic int pick_live_slot();
    int start;
    int k;
    start = $urandom_range(0, TABLE_ENTRIES - 1);
    for (k = 0; k < TABLE_ENTRIES; k++)
      if (tbl_valid[(start + k) % TABLE_ENTRIES]) return (start + k) % TABLE_ENTRIES;
    return -1;
  endfunction

  function automatic lpm_op_t random_op(input logic [KIND_W-1:0] kind);
    lpm_op_t op;
    op.kind = kind;
    op.is_ipv4 = 1'($urandom_range(0, 1));
    op.hi = rand64();
    op.lo = rand64();
    if ($urandom_range(0, 9) == 0) op.plen = 8'($urandom_range(0, 255));
    else op.plen = op.is_ipv4 ? 8'($urandom_range(0, 32)) : 8'($urandom_range(0, 128));
    return op;
  endfunction

  // key built from a stored prefix with junk beyond its length; widen lets searches go longer
  function automatic lpm_op_t op_from_entry(input logic [KIND_W-1:0] kind, input int slot,
                                            input bit widen);
    lpm_op_t op;
    logic [127:0] key;
    int unsigned klen;
    key = tbl_bits[slot] | ({rand64(), rand64()} & ~len_mask(tbl_len[slot]));
    klen = 32'(tbl_len[slot]);
    if (widen) klen = $urandom_range(klen, KEY_BITS);
    op.kind = kind;
    op.hi = key[127:64];
    op.lo = key[63:0];
    if (tbl_v4[slot] && $urandom_range(0, 4) != 0) begin
      op.is_ipv4 = 1'b1;
      op.hi = rand64();
      op.lo[63:32] = $urandom();
      op.plen = 8'(klen - IPV4_BASE_LEN);
      if (klen == KEY_BITS && $urandom_range(0, 3) == 0) op.plen = 8'($urandom_range(33, 255));
    end else begin
      op.is_ipv4 = 1'b0;
      op.plen = 8'(klen);
      if (klen == KEY_BITS && $urandom_range(0, 3) == 0)
        op.plen = 8'($urandom_range(129, 255));
    end
    return op;
  endfunction

  function automatic lpm_op_t next_random_op();
    int r;
    int slot;
    r = $urandom_range(0, 99);
    slot = pick_live_slot();
    if (r < 35) begin
      if (slot >= 0 && $urandom_range(0, 3) == 0) return op_from_entry(KIND_INSERT, slot, 1'b0);
      return random_op(KIND_INSERT);
    end
    if (r < 60) begin
      if (slot >= 0 && $urandom_range(0, 3) != 0) return op_from_entry(KIND_DELETE, slot, 1'b0);
      return random_op(KIND_DELETE);
    end
    if (r < 95) begin
      if (slot >= 0 && $urandom_range(0, 9) < 7) return op_from_entry(KIND_SEARCH, slot, 1'b1);
      return random_op(KIND_SEARCH);
    end
    return random_op(KIND_UNUSED);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
  endtask

  task automatic offer_beat(input lpm_op_t op, input logic typed, input lpm_reply_t want);
    lpm_reply_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= op.kind;
    in_is_ipv4 <= op.is_ipv4;
    in_address_high <= op.hi;
    in_address_low <= op.lo;
    in_prefix_length <= op.plen;
    @(posedge clk);
    while (in_stall) begin
      input_held++;
      @(posedge clk);
    end
    beats_sent++;
    r = apply_table_op(op);
    replies_due.push_back(typed ? want : r);
  endtask

  task automatic await_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic check_reply(input lpm_reply_t got);
    lpm_reply_t want;
    results_seen++;
    status_seen[got.status]++;
    if (replies_due.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with nothing outstanding", results_seen));
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                results_seen, got.status, want.status));
    if (got.index !== want.index)
      report_mismatch($sformatf("beat %0d index %0d, want %0d",
                                results_seen, got.index, want.index));
    if (got.length !== want.length)
      report_mismatch($sformatf("beat %0d length %0d, want %0d",
                                results_seen, got.length, want.length));
    if (got.is_ipv4 !== want.is_ipv4)
      report_mismatch($sformatf("beat %0d is_ipv4 %0d, want %0d",
                                results_seen, got.is_ipv4, want.is_ipv4));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_reply({out_status, out_match_index, out_match_length, out_match_is_ipv4});
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout: %0d results still outstanding", replies_due.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n;
    lpm_op_t op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 46;
    foreach (directed_rows[i])
      offer_beat(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
    for (n = 0; n < 450; n++) offer_beat(next_random_op(), 1'b0, UNTYPED);
    await_all_replies();

    send_idle_pct = 46;
    recv_idle_pct = 28;
    for (n = 0; n < 200; n++) offer_beat(next_random_op(), 1'b0, UNTYPED);
    hold_request = 1'b1;
    for (n = 0; n < 250; n++) offer_beat(next_random_op(), 1'b0, UNTYPED);
    await_all_replies();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // fill the table past capacity
    for (n = 0; n < 270; n++) begin
      op = random_op(KIND_INSERT);
      op.plen = op.is_ipv4 ? 8'd32 : 8'($urandom_range(64, 128));
      offer_beat(op, 1'b0, UNTYPED);
    end
    for (n = 0; n < 160; n++) offer_beat(next_random_op(), 1'b0, UNTYPED);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations in %0d cycles; input held off for %0d cycles",
             beats_sent, cycle_count, input_held);
    $display("results: %0d ok, %0d already present, %0d not found, %0d table full",
             status_seen[ST_OK], status_seen[ST_PRESENT], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL]);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: longest_prefix_match_table_core.f
hw/rtl/lpmt_pkg.sv
hw/rtl/lpmt_front.sv
hw/rtl/lpmt_queue.sv
hw/rtl/lpmt_back.sv
hw/rtl/longest_prefix_match_table_core.sv
test/longest_prefix_match_table_core_tb.sv
